// ===== sv/assert_macros.svh =====
// Assertion shorthands used by elgd_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, quiet while in reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, quiet while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/elgd_pkg.sv =====
package elgd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(DATA_W);
    localparam int unsigned PC_W   = 3;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [PC_W-1:0]   pc_t;
    typedef logic [0:0]        cfg_idx_t;

    localparam cfg_idx_t CFG_MODULUS     = 1'b0;
    localparam cfg_idx_t CFG_PRIVATE_KEY = 1'b1;

    typedef enum logic [1:0] {A_ONE, A_SQ, A_ACC} a_sel_t;
    typedef enum logic [1:0] {B_C1, B_SQ, B_ACC, B_C2} b_sel_t;
    typedef enum logic {D_SQ, D_ACC} dst_t;
    typedef enum logic [2:0] {JC_NONE, JC_ALWAYS, JC_ERR, JC_EZERO, JC_EEVEN} jcond_t;

    // program steps
    localparam pc_t PC_INIT   = 3'd0;
    localparam pc_t PC_REDUCE = 3'd1;
    localparam pc_t PC_TEST   = 3'd2;
    localparam pc_t PC_ODD    = 3'd3;
    localparam pc_t PC_MULACC = 3'd4;
    localparam pc_t PC_SQUARE = 3'd5;
    localparam pc_t PC_FINAL  = 3'd6;
    localparam pc_t PC_OUT    = 3'd7;

    typedef struct packed {
        logic   init;
        logic   mul;
        a_sel_t a_sel;
        b_sel_t b_sel;
        dst_t   dst;
        logic   shift_e;
        jcond_t jcond;
        pc_t    target;
        logic   finish;
    } uword_t;

    typedef struct packed {
        logic   init;
        logic   mul_start;
        a_sel_t a_sel;
        b_sel_t b_sel;
        dst_t   dst;
        logic   mul_wr;
        logic   shift_e;
        logic   finish;
    } dp_ctrl_t;

    typedef struct packed {
        logic err;
        logic e_zero;
        logic e_odd;
        logic mul_done;
        logic out_free;
    } dp_stat_t;

    // Control store: right-to-left square-and-multiply
    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        w = '0;
        case (pc)
            PC_INIT: begin
                w.init   = 1'b1;
                w.jcond  = JC_ERR;
                w.target = PC_OUT;
            end
            PC_REDUCE: begin
                // base mod m as 1 * c1
                w.mul   = 1'b1;
                w.a_sel = A_ONE;
                w.b_sel = B_C1;
                w.dst   = D_SQ;
            end
            PC_TEST: begin
                w.jcond  = JC_EZERO;
                w.target = PC_FINAL;
            end
            PC_ODD: begin
                w.jcond  = JC_EEVEN;
                w.target = PC_SQUARE;
            end
            PC_MULACC: begin
                w.mul   = 1'b1;
                w.a_sel = A_SQ;
                w.b_sel = B_ACC;
                w.dst   = D_ACC;
            end
            PC_SQUARE: begin
                w.mul     = 1'b1;
                w.a_sel   = A_SQ;
                w.b_sel   = B_SQ;
                w.dst     = D_SQ;
                w.shift_e = 1'b1;
                w.jcond   = JC_ALWAYS;
                w.target  = PC_TEST;
            end
            PC_FINAL: begin
                // c2 only feeds the serial operand, so it need not be reduced
                w.mul   = 1'b1;
                w.a_sel = A_ACC;
                w.b_sel = B_C2;
                w.dst   = D_ACC;
            end
            PC_OUT: begin
                w.finish = 1'b1;
            end
            default: begin
                w.finish = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/elgd_modmul.sv =====
// Interleaved modular multiplier, one bit of b per cycle, MSB first.
// Needs a < m; b may be any value.
module elgd_modmul
    import elgd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    input  word_t m,
    output logic  done,
    output word_t result
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            r_reg, r_next;
    word_t            b_reg, b_next;

    logic [DATA_W+1:0] r2, m1, m2, r_red;

    always_comb begin
        r2    = {1'b0, r_reg, 1'b0} + (b_reg[DATA_W-1] ? {2'b00, a} : '0);
        m1    = {2'b00, m};
        m2    = {1'b0, m, 1'b0};
        // r2 < 3m, so at most two subtractions
        if (r2 >= m2) begin
            r_red = r2 - m2;
        end else if (r2 >= m1) begin
            r_red = r2 - m1;
        end else begin
            r_red = r2;
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W - 1);
            r_next    = '0;
            b_next    = b;
        end else if (busy_reg) begin
            r_next   = r_red[DATA_W-1:0];
            b_next   = {b_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        b_reg   <= b_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// ===== sv/elgd_seq.sv =====
// Step counter over the control store, with conditional jumps.
module elgd_seq
    import elgd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     busy
);

    logic   busy_reg, busy_next;
    logic   wait_reg, wait_next;
    pc_t    pc_reg, pc_next;
    uword_t uw;
    logic   taken;
    logic   advance;

    always_comb begin
        uw = ucode(pc_reg);

        case (uw.jcond)
            JC_NONE:   taken = 1'b0;
            JC_ALWAYS: taken = 1'b1;
            JC_ERR:    taken = stat.err;
            JC_EZERO:  taken = stat.e_zero;
            JC_EEVEN:  taken = !stat.e_odd;
            default:   taken = 1'b0;
        endcase

        ctrl           = '0;
        ctrl.a_sel     = uw.a_sel;
        ctrl.b_sel     = uw.b_sel;
        ctrl.dst       = uw.dst;
        busy_next      = busy_reg;
        wait_next      = wait_reg;
        pc_next        = pc_reg;
        advance        = 1'b0;

        if (busy_reg) begin
            if (uw.mul) begin
                if (!wait_reg) begin
                    ctrl.mul_start = 1'b1;
                    wait_next      = 1'b1;
                end else if (stat.mul_done) begin
                    ctrl.mul_wr = 1'b1;
                    wait_next   = 1'b0;
                    advance     = 1'b1;
                end
            end else if (uw.finish) begin
                if (stat.out_free) begin
                    ctrl.finish = 1'b1;
                    busy_next   = 1'b0;
                end
            end else begin
                ctrl.init = uw.init;
                advance   = 1'b1;
            end
        end

        ctrl.shift_e = advance && uw.shift_e;
        if (advance) begin
            pc_next = taken ? uw.target : pc_t'(pc_reg + 1'b1);
        end

        if (start) begin
            busy_next = 1'b1;
            wait_next = 1'b0;
            pc_next   = PC_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            wait_reg <= 1'b0;
            pc_reg   <= PC_INIT;
        end else begin
            busy_reg <= busy_next;
            wait_reg <= wait_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== sv/elgamal_decrypt_modexp_core.sv =====
// Sequence: a reduction of c1, then per exponent bit a zero test, an odd test, a multiply
// into the accumulator when the bit is set and a squaring, then a final product with c2;
// the result then waits for a free output register. A key error goes straight to output.
// Throughput: one beat at a time; the next beat is taken once the sequencer is idle,
// even while the previous result still waits at the output register.
// Reset: synchronous active-low aresetn; modulus returns to 3, key to 0, no beat held.
module elgamal_decrypt_modexp_core
    import elgd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,

    input  logic     cfg_wr_en,
    input  cfg_idx_t cfg_index,
    input  word_t    cfg_wdata,

    input  logic     s_valid,
    output logic     s_ready,
    input  word_t    s_cipher_first,
    input  word_t    s_cipher_second,

    output logic     m_valid,
    input  logic     m_ready,
    output word_t    m_message,
    output logic     m_key_error
);

    word_t    modulus_reg, key_reg;
    word_t    c1_reg, c2_reg, acc_reg, sq_reg, e_reg;
    logic     err_reg;
    logic     m_valid_reg;
    word_t    message_reg;
    logic     key_error_reg;

    dp_ctrl_t ctrl;
    dp_stat_t stat;
    logic     busy;
    logic     accept;
    logic     cfg_err;
    word_t    mul_a, mul_b, mul_res;
    logic     mul_done;

    assign accept  = s_valid && s_ready;
    assign s_ready = !busy;

    // key must not exceed m - 2; a modulus below two is unusable
    assign cfg_err = (modulus_reg < word_t'(2)) || (key_reg > (modulus_reg - word_t'(2)));

    always_comb begin
        case (ctrl.a_sel)
            A_ONE:   mul_a = word_t'(1);
            A_SQ:    mul_a = sq_reg;
            A_ACC:   mul_a = acc_reg;
            default: mul_a = acc_reg;
        endcase
        case (ctrl.b_sel)
            B_C1:    mul_b = c1_reg;
            B_SQ:    mul_b = sq_reg;
            B_ACC:   mul_b = acc_reg;
            B_C2:    mul_b = c2_reg;
            default: mul_b = c2_reg;
        endcase
    end

    assign stat.err      = cfg_err;
    assign stat.e_zero   = (e_reg == '0);
    assign stat.e_odd    = e_reg[0];
    assign stat.mul_done = mul_done;
    assign stat.out_free = !m_valid_reg || m_ready;

    elgd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    elgd_modmul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .m       (modulus_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= word_t'(3);
            key_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MODULUS:     modulus_reg <= cfg_wdata;
                    CFG_PRIVATE_KEY: key_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (ctrl.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (accept) begin
            c1_reg <= s_cipher_first;
            c2_reg <= s_cipher_second;
        end
        if (ctrl.init) begin
            acc_reg <= word_t'(1);
            e_reg   <= modulus_reg - key_reg - word_t'(1);
            err_reg <= cfg_err;
        end
        if (ctrl.mul_wr) begin
            if (ctrl.dst == D_ACC) begin
                acc_reg <= mul_res;
            end else begin
                sq_reg <= mul_res;
            end
        end
        if (ctrl.shift_e) begin
            e_reg <= {1'b0, e_reg[DATA_W-1:1]};
        end
        if (ctrl.finish) begin
            message_reg   <= err_reg ? '0 : acc_reg;
            key_error_reg <= err_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_message   = message_reg;
    assign m_key_error = key_error_reg;

endmodule

// ===== sv/elgd_checker.sv =====
`include "assert_macros.svh"

module elgd_checker
    import elgd_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input word_t    m_message,
    input logic     m_key_error
);

    `ASSERT_NEXT(a_msg_hold, m_valid && !m_ready, m_valid && $stable(m_message), "beat dropped")
    `ASSERT_NEXT(a_err_hold, m_valid && !m_ready, $stable(m_key_error), "flag changed")
    `ASSERT_SAME(a_err_zero, m_valid && m_key_error, m_message == '0, "error beat carries data")
    `ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after a beat")
    `ASSERT_NEXT(a_no_instant_result, s_valid && s_ready, !$rose(m_valid), "result too early")

endmodule

bind elgamal_decrypt_modexp_core elgd_checker u_elgd_checker (.*);
